/* rtl/ab3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ab3_pkg
// Shared types, constants and the reciprocal table of the 3x3 alpha bleed.
// ----------------------------------------------------------------------------
package ab3_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam int SUM_W  = 11;
    localparam int CNT_W  = 4;
    localparam int RCP_W  = 17;
    localparam int RCP_SH = 16;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix;

    typedef t_pix [8:0] t_win;

    typedef struct packed {
        t_pix upper;
        t_pix mid;
    } t_lines;

    typedef struct packed {
        logic up;
        logic dn;
        logic lf;
        logic rt;
    } t_msk;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_SUM,
        S_MUL
    } t_state;

    // ceil(2^16 / c), exact for sums below 2^11
    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] c);
        logic [RCP_W-1:0] m;
        unique case (c)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13108;
            4'd6:    m = 17'd10923;
            4'd7:    m = 17'd9363;
            4'd8:    m = 17'd8192;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

/* rtl/ab3_line_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ab3_line_mem
// Two-row line buffer, one word per column: upper row and middle row.
// ----------------------------------------------------------------------------
module ab3_line_mem import ab3_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_lines        o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_lines        i_wr_data
);

    t_lines mem [DEPTH];
    t_lines r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/ab3_avg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ab3_avg
// Masked sum and count of opaque window pixels, then reciprocal divide.
// ----------------------------------------------------------------------------
module ab3_avg import ab3_pkg::*; (
    input  logic i_clk,
    input  logic i_load,
    input  t_win i_win,
    input  t_msk i_msk,
    output t_pix o_pix
);

    localparam int PW = SUM_W + RCP_W;

    logic [SUM_W-1:0] n_sr, n_sg, n_sb;
    logic [CNT_W-1:0] n_cnt;
    logic [SUM_W-1:0] r_sr, r_sg, r_sb;
    logic [CNT_W-1:0] r_cnt;
    t_pix             r_ctr;
    logic [RCP_W-1:0] rcp;
    logic [PW-1:0]    prod_r, prod_g, prod_b;

    always_comb begin
        logic nb_ok;
        n_sr  = '0;
        n_sg  = '0;
        n_sb  = '0;
        n_cnt = '0;
        for (int k = 0; k < 9; k++) begin
            nb_ok = !(k < 3 && i_msk.up) && !(k >= 6 && i_msk.dn)
                 && !((k % 3) == 0 && i_msk.lf) && !((k % 3) == 2 && i_msk.rt)
                 && (i_win[k].alpha != 8'd0);
            if (nb_ok) begin
                n_sr  = n_sr + SUM_W'(i_win[k].red);
                n_sg  = n_sg + SUM_W'(i_win[k].green);
                n_sb  = n_sb + SUM_W'(i_win[k].blue);
                n_cnt = n_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sr  <= n_sr;
            r_sg  <= n_sg;
            r_sb  <= n_sb;
            r_cnt <= n_cnt;
            r_ctr <= i_win[4];
        end
    end

    assign rcp    = recip(r_cnt);
    assign prod_r = PW'(r_sr) * PW'(rcp);
    assign prod_g = PW'(r_sg) * PW'(rcp);
    assign prod_b = PW'(r_sb) * PW'(rcp);

    always_comb begin
        o_pix = r_ctr;
        if (r_ctr.alpha == 8'd0 && r_cnt != '0) begin
            o_pix.red   = prod_r[RCP_SH+7:RCP_SH];
            o_pix.green = prod_g[RCP_SH+7:RCP_SH];
            o_pix.blue  = prod_b[RCP_SH+7:RCP_SH];
        end
    end

endmodule

/* rtl/alpha_bleed_3x3_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_bleed_3x3_filter
// Fills fully transparent pixels with the average of opaque 3x3 neighbors.
//
//  channel | handshake              | word
//  --------+------------------------+-----------------------------------------
//  cfg     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//  in      | i_valid/o_stall        | i_req_type, i_in_red/green/blue/alpha
//  out     | o_valid/i_stall        | o_out_red/green/blue/alpha, o_frame_last
//
// An ignored drain leaves the control idle. Every other item passes the line
// buffer read-modify-write; an item with a result then passes the masked sum
// stage and the reciprocal multiply, which waits while the output word stalls.
// The next word is taken while a result waits in the output register.
// Reset clears control and window; the line buffer needs no clearing pass.
// A width or height write restarts the frame.
// ----------------------------------------------------------------------------
module alpha_bleed_3x3_filter import ab3_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_req_type,
    input  logic [7:0]           i_in_red,
    input  logic [7:0]           i_in_green,
    input  logic [7:0]           i_in_blue,
    input  logic [7:0]           i_in_alpha,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_out_red,
    output logic [7:0]           o_out_green,
    output logic [7:0]           o_out_blue,
    output logic [7:0]           o_out_alpha,
    output logic                 o_frame_last
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int CWW   = (WW > CFG_W) ? WW : CFG_W;
    localparam int CHW   = (HW > CFG_W) ? HW : CFG_W;
    localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    t_state        r_state, n_state;
    logic [WW-1:0] r_w;
    logic [HW-1:0] r_h;
    logic [AW-1:0] r_col;
    logic [RW-1:0] r_row;
    t_pix          r_pix;
    t_win          r_win, n_win;
    t_msk          r_msk, n_msk;
    logic          r_last, n_last;
    t_pix          r_out;
    logic          r_out_last;
    logic          r_out_valid;

    logic          acc, drop, in_frame, out_load, emit, wrap, col0;
    logic [WW-1:0] col_w, pc, w_val;
    logic [HW-1:0] h_val;
    logic [RW-1:0] pr;
    logic [CWW-1:0] cfg_wx;
    logic [CHW-1:0] cfg_hx;
    t_lines        rd_lines, wr_lines;
    t_pix          avg_pix;

    // clamped sizes
    always_comb begin
        cfg_wx = CWW'(i_cfg_data);
        cfg_hx = CHW'(i_cfg_data);
        if (cfg_wx == '0) begin
            w_val = WW'(1);
        end else if (cfg_wx > CWW'(MAX_WIDTH)) begin
            w_val = WW'(MAX_WIDTH);
        end else begin
            w_val = WW'(cfg_wx);
        end
        if (cfg_hx == '0) begin
            h_val = HW'(1);
        end else if (cfg_hx > CHW'(MAX_HEIGHT)) begin
            h_val = HW'(MAX_HEIGHT);
        end else begin
            h_val = HW'(cfg_hx);
        end
    end

    // position of the pixel leaving the window
    always_comb begin
        col_w    = WW'(r_col);
        col0     = (r_col == '0);
        in_frame = r_row < RW'(r_h);
        pr       = col0 ? r_row - RW'(2) : r_row - RW'(1);
        pc       = col0 ? r_w - WW'(1) : col_w - WW'(1);
        emit     = (r_row >= RW'(2)) || (r_row == RW'(1) && !col0);
        wrap     = (col_w + WW'(1)) >= r_w;
        n_msk.up = (pr == '0);
        n_msk.dn = (pr + RW'(1)) >= RW'(r_h);
        n_msk.lf = (pc == '0);
        n_msk.rt = (pc + WW'(1)) >= r_w;
        n_last   = (pr == RW'(r_h) - RW'(1)) && (pc == r_w - WW'(1));
    end

    always_comb begin
        n_win = r_win;
        for (int k = 0; k < 3; k++) begin
            n_win[k*3+0] = r_win[k*3+1];
            n_win[k*3+1] = r_win[k*3+2];
        end
        n_win[2] = rd_lines.upper;
        n_win[5] = rd_lines.mid;
        n_win[8] = r_pix;
    end

    assign wr_lines.upper = rd_lines.mid;
    assign wr_lines.mid   = r_pix;

    ab3_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (acc),
        .i_rd_addr (r_col),
        .o_rd_data (rd_lines),
        .i_wr_en   (r_state == S_UPD),
        .i_wr_addr (r_col),
        .i_wr_data (wr_lines)
    );

    ab3_avg u_avg (
        .i_clk  (i_clk),
        .i_load (r_state == S_SUM),
        .i_win  (r_win),
        .i_msk  (r_msk),
        .o_pix  (avg_pix)
    );

    // control
    always_comb begin
        o_stall  = (r_state != S_IDLE);
        acc      = i_valid && !o_stall;
        drop     = (i_req_type == REQ_DRAIN) && in_frame;
        out_load = 1'b0;
        n_state  = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc && !drop) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = emit ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w         <= WW'(W_RST);
            r_h         <= HW'(H_RST);
            r_col       <= '0;
            r_row       <= '0;
            r_win       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_UPD) begin
                r_win <= n_win;
                if (emit && n_last) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (wrap) begin
                    r_col <= '0;
                    r_row <= r_row + RW'(1);
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_WIDTH: begin
                        r_w   <= w_val;
                        r_col <= '0;
                        r_row <= '0;
                    end
                    REG_HEIGHT: begin
                        r_h   <= h_val;
                        r_col <= '0;
                        r_row <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (in_frame) begin
                r_pix <= '{alpha: i_in_alpha, blue: i_in_blue,
                           green: i_in_green, red: i_in_red};
            end else begin
                r_pix <= '0;
            end
        end
        if (r_state == S_UPD) begin
            r_msk  <= n_msk;
            r_last <= n_last;
        end
        if (out_load) begin
            r_out      <= avg_pix;
            r_out_last <= r_last;
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_out_valid;
    assign o_out_red    = r_out.red;
    assign o_out_green  = r_out.green;
    assign o_out_blue   = r_out.blue;
    assign o_out_alpha  = r_out.alpha;
    assign o_frame_last = r_out_last;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < r_w)
        else $error("input column beyond image width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= RW'(r_h) + RW'(1))
        else $error("input row beyond frame drain");

    a_mul_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_out_valid && i_stall)
            |=> (r_state == S_MUL && o_valid))
        else $error("result lost while output word stalled");

endmodule
